[sv/alro_pkg.sv]
// alro_pkg: shared types, action codes and arithmetic constants for the looper.
// No dependencies; used by every module of audio_loop_recorder_overdub except alro_ram.
package alro_pkg;

  localparam int BUFFER_DEPTH = 16777216;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;
  localparam logic [1:0] ACT_PLAY   = 2'd2;
  localparam logic [1:0] ACT_RESET  = 2'd3;

  localparam logic [6:0] WET_MAX = 7'd100;

  localparam logic signed [15:0] SAT_MAX = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN = -16'sd32767;

  // x / 25 as (x * RECIP) >> RECIP_SHIFT, low by at most one for x < 2**21
  localparam int RECIP_SHIFT = 24;
  localparam logic [19:0] RECIP = 20'((1 << RECIP_SHIFT) / 25);

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] sample_in;
    logic [6:0]         wet_level;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               playing;
    logic               recording;
    logic               capturing;
  } out_t;

  typedef struct packed {
    logic playing;
    logic recording;
    logic capturing;
  } flags_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] dry;
    logic [6:0]         wet;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[sv/alro_ram.sv]
// alro_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module alro_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

[sv/alro_front.sv]
// alro_front: input handshake and item classification (wet level clamp).
// Depends on alro_pkg.
module alro_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  alro_pkg::in_t     in_data,
  input  alro_pkg::q_stat_t q_stat,
  output logic              push,
  output alro_pkg::item_t   push_item
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.action = in_data.action;
    push_item.dry    = in_data.sample_in;
    push_item.wet    = (in_data.wet_level > alro_pkg::WET_MAX) ? alro_pkg::WET_MAX
                                                               : in_data.wet_level;
  end

endmodule

[sv/alro_fifo.sv]
// alro_fifo: two-entry queue between the front end and the back end.
// Depends on alro_pkg.
module alro_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  alro_pkg::item_t   push_item,
  input  logic              pop,
  output alro_pkg::item_t   pop_item,
  output alro_pkg::q_stat_t q_stat
);

  alro_pkg::item_t slot_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;

  assign pop_item     = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

[sv/alro_back.sv]
// alro_back: executes queued items against the loop store and looper state,
// then mixes the output through a short arithmetic pipeline.
// Depends on alro_pkg and alro_ram.
module alro_back #(
  parameter int DEPTH = alro_pkg::BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  alro_pkg::item_t   pop_item,
  input  alro_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output alro_pkg::out_t    out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);
  localparam logic [LW-1:0] ONE_L   = LW'(1);

  typedef struct packed {
    logic                audio;
    logic signed [15:0]  dry;
    logic signed [22:0]  prod;
    alro_pkg::flags_t    flags;
  } tst_t;

  typedef struct packed {
    logic                audio;
    logic                neg;
    logic [20:0]         y;
    alro_pkg::flags_t    flags;
  } mst_t;

  typedef struct packed {
    logic                audio;
    logic                neg;
    logic [20:0]         y;
    logic [16:0]         q0;
    alro_pkg::flags_t    flags;
  } qst_t;

  // looper state
  logic [AW-1:0] head_r, head_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] take_r, take_nxt;
  logic [LW-1:0] fill_r, fill_nxt;   // entries at or above this read as zero
  logic          play_r, play_nxt;
  logic          rec_r, rec_nxt;
  logic          first_r, first_nxt;

  // execute stage (store read data valid here)
  logic            d_vld_r;
  alro_pkg::item_t d_item_r;

  logic       t_vld_r, m_vld_r, q_vld_r, out_vld_r;
  tst_t       t_r;
  mst_t       m_r;
  qst_t       q_r;
  alro_pkg::out_t out_r;

  logic o_free, q_free, m_free, t_free, d_go;

  logic [15:0]        rd_data;
  logic               wr_en;
  logic signed [15:0] wr_data;

  logic [LW-1:0]      head_l, head_inc;
  logic signed [15:0] stored;
  logic signed [15:0] loop_val;
  logic signed [16:0] sum;
  logic signed [22:0] mix_prod;

  logic signed [25:0] tot;
  logic [25:0]        mag, rnd;
  logic [40:0]        recip_prod;
  logic [21:0]        rem;
  logic [17:0]        quo;
  logic [15:0]        mag16;
  logic signed [15:0] res;

  assign o_free = !out_vld_r || out_ready;
  assign q_free = !q_vld_r || o_free;
  assign m_free = !m_vld_r || q_free;
  assign t_free = !t_vld_r || m_free;
  assign d_go   = d_vld_r && t_free;

  // one item in execute at a time; the read for the next follows the write
  assign pop = !q_stat.empty && !d_vld_r;

  alro_ram #(
    .W     (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign head_l   = LW'(head_r);
  assign head_inc = head_l + ONE_L;
  assign stored   = (head_l < fill_r) ? $signed(rd_data) : 16'sd0;
  assign sum      = 17'(stored) + 17'(d_item_r.dry);
  assign wr_data  = (sum > 17'sd32767)  ? alro_pkg::SAT_MAX :
                    (sum < -17'sd32767) ? alro_pkg::SAT_MIN : sum[15:0];
  // the mix sees the store after this item's overdub
  assign loop_val = rec_r ? wr_data : stored;
  assign mix_prod = play_r ? 23'(loop_val) * 23'($signed({1'b0, d_item_r.wet})) : 23'sd0;

  always_comb begin
    head_nxt  = head_r;
    len_nxt   = len_r;
    take_nxt  = take_r;
    fill_nxt  = fill_r;
    play_nxt  = play_r;
    rec_nxt   = rec_r;
    first_nxt = first_r;
    wr_en     = 1'b0;
    unique case (d_item_r.action)
      alro_pkg::ACT_SAMPLE: begin
        if (rec_r) begin
          wr_en = d_go;
          if (head_inc > fill_r) fill_nxt = head_inc;
          if (first_r) take_nxt = take_r + ONE_L;
        end
        // a first take that fills the whole store closes by itself
        if (take_nxt >= DEPTH_L) begin
          first_nxt = 1'b0;
          len_nxt   = DEPTH_L;
          take_nxt  = '0;
        end
        if (play_r) head_nxt = (head_inc >= len_nxt) ? '0 : head_inc[AW-1:0];
      end
      alro_pkg::ACT_RECORD: begin
        if (first_r && rec_r) begin
          first_nxt = 1'b0;
          len_nxt   = (take_r == '0) ? ONE_L : take_r;
          take_nxt  = '0;
        end
        play_nxt = 1'b1;
        rec_nxt  = !rec_r;
      end
      alro_pkg::ACT_PLAY: begin
        if (!(first_r && !rec_r)) begin
          play_nxt = !play_r;
          rec_nxt  = 1'b0;
        end
      end
      alro_pkg::ACT_RESET: begin
        if (play_r) begin
          head_nxt  = '0;
          len_nxt   = DEPTH_L;
          take_nxt  = '0;
          fill_nxt  = '0;
          play_nxt  = 1'b0;
          rec_nxt   = 1'b0;
          first_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      len_r   <= DEPTH_L;
      take_r  <= '0;
      fill_r  <= '0;
      play_r  <= 1'b0;
      rec_r   <= 1'b0;
      first_r <= 1'b1;
      d_vld_r <= 1'b0;
    end else begin
      if (d_go) begin
        head_r  <= head_nxt;
        len_r   <= len_nxt;
        take_r  <= take_nxt;
        fill_r  <= fill_nxt;
        play_r  <= play_nxt;
        rec_r   <= rec_nxt;
        first_r <= first_nxt;
      end
      if (pop)       d_vld_r <= 1'b1;
      else if (d_go) d_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) d_item_r <= pop_item;
  end

  // mix: total = dry*200 + stored*wet*3, then round(total / 200)
  assign tot = 26'(t_r.dry) * 26'sd200 + 26'(t_r.prod) * 26'sd3;
  assign mag = tot[25] ? 26'(-tot) : 26'(tot);
  assign rnd = mag + 26'd100;

  assign recip_prod = 41'(m_r.y) * 41'(alro_pkg::RECIP);

  // quotient estimate is low by at most one
  assign rem   = 22'(q_r.y) - 22'(q_r.q0) * 22'd25;
  assign quo   = 18'(q_r.q0) + ((rem >= 22'd25) ? 18'd1 : 18'd0);
  assign mag16 = (quo > 18'd32767) ? 16'd32767 : quo[15:0];
  assign res   = !q_r.audio ? 16'sd0 :
                 q_r.neg    ? 16'(-$signed(mag16)) : $signed(mag16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r   <= 1'b0;
      m_vld_r   <= 1'b0;
      q_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (t_free) t_vld_r   <= d_vld_r;
      if (m_free) m_vld_r   <= t_vld_r;
      if (q_free) q_vld_r   <= m_vld_r;
      if (o_free) out_vld_r <= q_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_go) begin
      t_r.audio <= (d_item_r.action == alro_pkg::ACT_SAMPLE);
      t_r.dry   <= d_item_r.dry;
      t_r.prod  <= mix_prod;
      t_r.flags <= '{playing: play_nxt, recording: rec_nxt, capturing: first_nxt};
    end
    if (t_vld_r && m_free) begin
      m_r.audio <= t_r.audio;
      m_r.neg   <= tot[25];
      m_r.y     <= rnd[23:3];
      m_r.flags <= t_r.flags;
    end
    if (m_vld_r && q_free) begin
      q_r.audio <= m_r.audio;
      q_r.neg   <= m_r.neg;
      q_r.y     <= m_r.y;
      q_r.q0    <= recip_prod[alro_pkg::RECIP_SHIFT +: 17];
      q_r.flags <= m_r.flags;
    end
    if (q_vld_r && o_free) begin
      out_r.sample_out <= res;
      out_r.playing    <= q_r.flags.playing;
      out_r.recording  <= q_r.flags.recording;
      out_r.capturing  <= q_r.flags.capturing;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[sv/audio_loop_recorder_overdub.sv]
// audio_loop_recorder_overdub: top level of the mono overdub looper.
// Depends on alro_pkg, alro_front, alro_fifo, alro_back (and alro_ram below it).
//
// Every accepted transaction (audio sample or button action) yields exactly one
// result transaction, in order. The back end handles one item at a time: a loop
// store read at the head, then an execute step in which the store is written
// (read-modify-write on the single RAM port pair) and the looper state advances;
// it pops the next item only after the current one has executed. The mix then
// runs through three more register stages and the output register, which drives
// out_valid. A two-entry input queue lets the front accept while the back end is
// busy; with the output stalled, 7 transactions fit in flight before in_ready
// drops. The store is not swept on a reset gesture or after rst_n: a fill mark
// makes never-written entries read as zero, so reset takes effect at once and no
// clearing pass is needed.
module audio_loop_recorder_overdub #(
  parameter int BUFFER_DEPTH = alro_pkg::BUFFER_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  alro_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output alro_pkg::out_t out_data
);

  logic              push;
  logic              pop;
  alro_pkg::item_t   push_item;
  alro_pkg::item_t   pop_item;
  alro_pkg::q_stat_t q_stat;

  alro_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  alro_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  alro_back #(
    .DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/alro_checker.sv]
// alro_checker: port-level assertions for audio_loop_recorder_overdub, plus bind.
// Depends on alro_pkg.
module alro_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input alro_pkg::out_t out_data
);

  logic       in_acc, out_acc;
  logic [3:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= 4'(pend_r + {3'b0, in_acc} - {3'b0, out_acc});
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result offered with no transaction outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd7)
    else $error("more transactions in flight than the queue and stages hold");

  a_rec_plays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.recording |-> out_data.playing)
    else $error("recording reported while not playing");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sample_out != -16'sd32768)
    else $error("output sample outside saturation range");

endmodule

bind audio_loop_recorder_overdub alro_checker u_alro_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
